@@ hdl/sorted_keyed_record_table_top_macros.svh @@
// Assertion macros for the record table
`ifndef SORTED_KEYED_RECORD_TABLE_TOP_MACROS_SVH
`define SORTED_KEYED_RECORD_TABLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SKRT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("record table check failed");
`define SKRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("record table check failed");
`else
`define SKRT_ASSERT_SAME(label, ante, cons)
`define SKRT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/skrt_pkg.sv @@
`default_nettype none

package skrt_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_DUMP   = 2'd2;

    localparam logic [2:0] STAT_INSERTED = 3'd0;
    localparam logic [2:0] STAT_DELETED  = 3'd1;
    localparam logic [2:0] STAT_NOTFOUND = 3'd2;
    localparam logic [2:0] STAT_FULL     = 3'd3;
    localparam logic [2:0] STAT_ENTRY    = 3'd4;
    localparam logic [2:0] STAT_EMPTY    = 3'd5;

    // key in the lowest bits, name_high on top
    typedef struct packed {
        logic [31:0] name_high;
        logic [63:0] name_mid;
        logic [63:0] name_low;
        logic [7:0]  age;
        logic [15:0] key;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

endpackage

`default_nettype wire

@@ hdl/sorted_keyed_record_table_top.sv @@
// Sorted record table: up to CAPACITY records (key, age, 20-byte name) in ascending key order.
// Slave channel: one request per item, tuser = mode (insert, delete, dump),
// tdata = key, age and name. Master channel: result items, tuser = status,
// tlast marks the final result of a request.
// A single record RAM and one key comparator are stepped by a small sequencer;
// each step reads one entry (ST_RD) and compares/moves it (ST_CMP).
// Insert: a full table gives STAT_FULL with no scan; otherwise the scan covers every
// record with a key not below the new key and the first record below it, if any.
// Delete: scans every record held, or gives STAT_NOTFOUND with no scan if the table is empty.
// Dump: one result per record in key order; the scan waits while the receiver stalls.
// A new request is taken only when the previous one has finished; its result
// may still sit in the output register meanwhile.
// Reset empties the table; RAM contents are not cleared and need no pass.
// When the receiver stalls, the result is held in the output register and
// the sequencer waits before producing the next result.
`default_nettype none

module sorted_keyed_record_table_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // key[15:0], age[23:16], name_low[87:24], name_mid[151:88], name_high[183:152]
    input  wire logic [183:0] i_s_tdata,
    // mode[1:0]
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // out_key[15:0], out_age[23:16], out_name_low[87:24], out_name_mid[151:88],
    // out_name_high[183:152], entry_count[188:184], zero pad[191:189]
    output logic [191:0]      o_m_tdata,
    // status[2:0]
    output logic [2:0]        o_m_tuser,
    output logic              o_m_tlast
);

    `include "sorted_keyed_record_table_top_macros.svh"

    localparam int AW = skrt_pkg::ADDR_W;
    localparam int CW = skrt_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_WRNEW = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]        r_state,  n_state;
    logic [1:0]        r_mode,   n_mode;
    skrt_pkg::t_rec    r_rec,    n_rec;
    logic [CW-1:0]     r_idx,    n_idx;
    logic [AW-1:0]     r_pos,    n_pos;
    logic              r_found,  n_found;
    logic [CW-1:0]     r_count,  n_count;
    logic [2:0]        r_status, n_status;

    logic              r_ovalid,  n_ovalid;
    logic [2:0]        r_ostatus, n_ostatus;
    skrt_pkg::t_rec    r_orec,    n_orec;
    logic [CW-1:0]     r_ocount,  n_ocount;
    logic              r_olast,   n_olast;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    skrt_pkg::t_rec           ram_wdata;
    logic [skrt_pkg::REC_W-1:0] ram_rdata;
    skrt_pkg::t_rec           rd_rec;

    logic              out_free;
    logic              found_now;
    logic              at_end;
    logic              in_acc;
    logic              full_insert;
    logic              dump_step;

    skrt_ram #(
        .WIDTH (skrt_pkg::REC_W),
        .DEPTH (skrt_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_rec    = skrt_pkg::t_rec'(ram_rdata);
    assign out_free  = !r_ovalid || i_m_tready;
    assign found_now = r_found || (rd_rec.key == r_rec.key);
    assign at_end    = (r_idx == r_count - CW'(1));
    assign in_acc    = i_s_tvalid && o_s_tready;
    assign full_insert = in_acc && (i_s_tuser == skrt_pkg::MODE_INSERT)
                         && (r_count == CW'(skrt_pkg::CAPACITY));
    assign dump_step   = (r_state == ST_CMP) && (r_mode == skrt_pkg::MODE_DUMP);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_rec     = r_rec;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_found   = r_found;
        n_count   = r_count;
        n_status  = r_status;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_orec    = r_orec;
        n_ocount  = r_ocount;
        n_olast   = r_olast;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = rd_rec;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_mode  = i_s_tuser;
                    n_rec   = skrt_pkg::t_rec'(i_s_tdata);
                    n_found = 1'b0;
                    n_idx   = '0;
                    unique case (i_s_tuser)
                        skrt_pkg::MODE_INSERT: begin
                            if (r_count >= CW'(skrt_pkg::CAPACITY)) begin
                                n_status = skrt_pkg::STAT_FULL;
                                n_state  = ST_EMIT;
                            end else if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = ST_WRNEW;
                            end else begin
                                n_idx   = r_count - CW'(1);
                                n_state = ST_RD;
                            end
                        end
                        skrt_pkg::MODE_DELETE: begin
                            if (r_count == '0) begin
                                n_status = skrt_pkg::STAT_NOTFOUND;
                                n_state  = ST_EMIT;
                            end else begin
                                n_state = ST_RD;
                            end
                        end
                        skrt_pkg::MODE_DUMP: begin
                            if (r_count == '0) begin
                                n_status = skrt_pkg::STAT_EMPTY;
                                n_state  = ST_EMIT;
                            end else begin
                                n_state = ST_RD;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                unique case (r_mode)
                    skrt_pkg::MODE_INSERT: begin
                        if (rd_rec.key >= r_rec.key) begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_idx + CW'(1));
                            if (r_idx == '0) begin
                                n_pos   = '0;
                                n_state = ST_WRNEW;
                            end else begin
                                n_idx   = r_idx - CW'(1);
                                n_state = ST_RD;
                            end
                        end else begin
                            n_pos   = AW'(r_idx + CW'(1));
                            n_state = ST_WRNEW;
                        end
                    end
                    skrt_pkg::MODE_DELETE: begin
                        // entries after the match close the gap
                        if (r_found) begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_idx - CW'(1));
                        end
                        n_found = found_now;
                        if (at_end) begin
                            if (found_now) begin
                                n_count  = r_count - CW'(1);
                                n_status = skrt_pkg::STAT_DELETED;
                            end else begin
                                n_status = skrt_pkg::STAT_NOTFOUND;
                            end
                            n_state = ST_EMIT;
                        end else begin
                            n_idx   = r_idx + CW'(1);
                            n_state = ST_RD;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            n_ovalid  = 1'b1;
                            n_ostatus = skrt_pkg::STAT_ENTRY;
                            n_orec    = rd_rec;
                            n_ocount  = r_count;
                            n_olast   = at_end;
                            if (at_end) begin
                                n_state = ST_IDLE;
                            end else begin
                                n_idx   = r_idx + CW'(1);
                                n_state = ST_RD;
                            end
                        end
                    end
                endcase
            end
            ST_WRNEW: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_rec;
                n_count   = r_count + CW'(1);
                n_status  = skrt_pkg::STAT_INSERTED;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_orec    = '0;
                    n_ocount  = r_count;
                    n_olast   = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_found  <= n_found;
        end
        r_mode    <= n_mode;
        r_rec     <= n_rec;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_status  <= n_status;
        r_ostatus <= n_ostatus;
        r_orec    <= n_orec;
        r_ocount  <= n_ocount;
        r_olast   <= n_olast;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {3'b000, r_ocount, r_orec};

    `SKRT_ASSERT_SAME(a_count_range, 1'b1, r_count <= CW'(skrt_pkg::CAPACITY))
    `SKRT_ASSERT_SAME(a_no_write_idle, r_state == ST_IDLE, !ram_we)
    `SKRT_ASSERT_NEXT(a_full_keeps, full_insert, r_count == $past(r_count))
    `SKRT_ASSERT_NEXT(a_dump_keeps, dump_step, $stable(r_count))

endmodule

`default_nettype wire

@@ hdl/skrt_ram.sv @@
`default_nettype none

module skrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ bench/sorted_keyed_record_table_top_test.sv @@
`timescale 1ns / 1ps

module sorted_keyed_record_table_top_test;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [2:0]     status;
        logic           last;
        logic [4:0]     count;
        skrt_pkg::t_rec rec;
    } t_table_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [183:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [191:0] o_m_tdata;
    logic [2:0]   o_m_tuser;
    logic         o_m_tlast;

    skrt_pkg::t_rec shadow_rec [skrt_pkg::CAPACITY];
    int             shadow_count = 0;
    t_table_result  pending_results [$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    bit             quiet = 1'b0;

    sorted_keyed_record_table_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sorted_keyed_record_table_top");
            $finish;
        end
    end

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    function automatic void push_result(input logic [2:0] status,
                                        input skrt_pkg::t_rec rec,
                                        input logic last);
        t_table_result r;
        r.status = status;
        r.last   = last;
        r.count  = shadow_count[4:0];
        r.rec    = rec;
        pending_results.push_back(r);
    endfunction

    // shadow copy of the table; queues the results each request should give
    function automatic void apply_to_shadow_table(input logic [1:0] mode,
                                                  input skrt_pkg::t_rec req);
        int pos;
        if (mode == skrt_pkg::MODE_INSERT) begin
            if (shadow_count >= skrt_pkg::CAPACITY) begin
                push_result(skrt_pkg::STAT_FULL, '0, 1'b1);
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_rec[pos].key < req.key)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                    shadow_rec[i] = shadow_rec[i - 1];
                shadow_rec[pos] = req;
                shadow_count++;
                push_result(skrt_pkg::STAT_INSERTED, '0, 1'b1);
            end
        end else if (mode == skrt_pkg::MODE_DELETE) begin
            pos = 0;
            while (pos < shadow_count && shadow_rec[pos].key != req.key)
                pos++;
            if (pos >= shadow_count) begin
                push_result(skrt_pkg::STAT_NOTFOUND, '0, 1'b1);
            end else begin
                for (int i = pos; i + 1 < shadow_count; i++)
                    shadow_rec[i] = shadow_rec[i + 1];
                shadow_count--;
                push_result(skrt_pkg::STAT_DELETED, '0, 1'b1);
            end
        end else if (mode == skrt_pkg::MODE_DUMP) begin
            if (shadow_count == 0)
                push_result(skrt_pkg::STAT_EMPTY, '0, 1'b1);
            else
                for (int i = 0; i < shadow_count; i++)
                    push_result(skrt_pkg::STAT_ENTRY, shadow_rec[i], i + 1 == shadow_count);
        end
    endfunction

    function automatic skrt_pkg::t_rec random_record(input logic [15:0] key);
        skrt_pkg::t_rec r;
        r.key       = key;
        r.age       = 8'($urandom);
        r.name_low  = {$urandom, $urandom};
        r.name_mid  = {$urandom, $urandom};
        r.name_high = $urandom;
        return r;
    endfunction

    function automatic logic [15:0] insert_key();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0 && shadow_count > 0)
            return shadow_rec[$urandom_range(0, shadow_count - 1)].key;
        else if (pick == 1)
            return 16'($urandom_range(0, 31));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] delete_key();
        if (shadow_count > 0 && $urandom_range(0, 3) != 0)
            return shadow_rec[$urandom_range(0, shadow_count - 1)].key;
        return 16'($urandom_range(0, 31));
    endfunction

    task automatic send_request(input logic [1:0] mode, input skrt_pkg::t_rec rec);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= rec;
        do @(posedge i_clk); while (!o_s_tready);
        apply_to_shadow_table(mode, rec);
    endtask

    always begin : result_stall
        int n;
        n = $urandom_range(1, 40);
        repeat (n) begin
            @(negedge i_clk);
            i_m_tready <= 1'b1;
        end
        if (!quiet) begin
            n = $urandom_range(1, 18);
            repeat (n) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_table_result got;
        t_table_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = o_m_tuser;
            got.last   = o_m_tlast;
            got.count  = o_m_tdata[188:184];
            got.rec    = o_m_tdata[183:0];
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result: status %0d key %h count %0d",
                                       got.status, got.rec.key, got.count));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.last !== want.last ||
                    got.count !== want.count || got.rec.key !== want.rec.key ||
                    got.rec.age !== want.rec.age ||
                    got.rec.name_low !== want.rec.name_low ||
                    got.rec.name_mid !== want.rec.name_mid ||
                    got.rec.name_high !== want.rec.name_high)
                    note_failure($sformatf({"mismatch: want status %0d last %b count %0d ",
                        "key %h age %h name %h %h %h; got status %0d last %b count %0d ",
                        "key %h age %h name %h %h %h"},
                        want.status, want.last, want.count, want.rec.key, want.rec.age,
                        want.rec.name_low, want.rec.name_mid, want.rec.name_high,
                        got.status, got.last, got.count, got.rec.key, got.rec.age,
                        got.rec.name_low, got.rec.name_mid, got.rec.name_high));
            end
        end
    end

    task automatic test_empty_table();
        send_request(skrt_pkg::MODE_DUMP, random_record(16'h0000));
        send_request(skrt_pkg::MODE_DELETE, random_record(16'h0000));
        send_request(MODE_NOP, '1);
    endtask

    task automatic test_extreme_records();
        send_request(skrt_pkg::MODE_INSERT, '0);
        send_request(skrt_pkg::MODE_INSERT, '1);
        send_request(skrt_pkg::MODE_DUMP, '0);
    endtask

    // equal keys: newest goes first, delete takes the first match
    task automatic test_duplicate_keys();
        send_request(skrt_pkg::MODE_INSERT, random_record(16'h8000));
        send_request(skrt_pkg::MODE_INSERT, random_record(16'h8000));
        send_request(skrt_pkg::MODE_DELETE, random_record(16'h8000));
        send_request(skrt_pkg::MODE_DELETE, random_record(16'h1234));
    endtask

    task automatic test_fill_to_capacity();
        while (shadow_count < skrt_pkg::CAPACITY)
            send_request(skrt_pkg::MODE_INSERT, random_record(16'($urandom)));
        send_request(skrt_pkg::MODE_INSERT, random_record(16'h4000));
        send_request(skrt_pkg::MODE_DUMP, random_record(16'h0000));
    endtask

    task automatic test_random_traffic(input int n_items);
        int   sent;
        int   roll;
        bit   filling;
        logic [1:0] mode;
        sent = 0;
        filling = 1'b1;
        while (sent < n_items) begin
            if (shadow_count == skrt_pkg::CAPACITY && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (shadow_count == 0 || $urandom_range(0, 40) == 0)
                filling = !filling || shadow_count == 0;
            roll = $urandom_range(0, 99);
            if (roll < 5)
                mode = MODE_NOP;
            else if (roll < 15)
                mode = skrt_pkg::MODE_DUMP;
            else if ((roll < 70) == filling)
                mode = skrt_pkg::MODE_INSERT;
            else
                mode = skrt_pkg::MODE_DELETE;
            if (mode == skrt_pkg::MODE_DELETE)
                send_request(mode, random_record(delete_key()));
            else
                send_request(mode, random_record(insert_key()));
            if (mode != MODE_NOP)
                sent++;
        end
    endtask

    task automatic test_tail_without_stalls();
        quiet = 1'b1;
        test_random_traffic(40);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_extreme_records();
        test_duplicate_keys();
        test_fill_to_capacity();
        test_random_traffic(245);
        test_tail_without_stalls();

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));

        if (mismatch_count == 0)
            $display("PASS sorted_keyed_record_table_top");
        else
            $display("FAIL sorted_keyed_record_table_top");
        $finish;
    end

endmodule
